### src/iort_pkg.sv
`timescale 1ns / 1ps

package iort_pkg;

  localparam int ENTRIES_DEF   = 64;
  localparam int TIME_BITS_DEF = 32;

  localparam int REQ_TIME_W = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  localparam logic [STATUS_W-1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

  typedef struct packed {
    logic signed [REQ_TIME_W-1:0] req_start;
    logic signed [REQ_TIME_W-1:0] req_end;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  stored_count;
  } out_rsp_t;

endpackage

### src/interval_overlap_reservation_table.sv
// Each request is accepted in ST_IDLE, reads the N held bookings in ST_SCAN, then passes ST_DRAIN
// and ST_DECIDE before the out_valid strobe; an empty table goes from ST_IDLE straight to ST_DECIDE.
// The next request is taken in the strobe cycle; none is taken while busy. The scan of the
// booking memory uses one read port, one entry per cycle.
// Reset clears the booking count and the control state; the memory holds garbage until written, no sweep.
// The receiver cannot stall: each result is flagged by out_valid for exactly one cycle.
`timescale 1ns / 1ps

module interval_overlap_reservation_table #(
  parameter int ENTRIES   = iort_pkg::ENTRIES_DEF,
  parameter int TIME_BITS = iort_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  iort_pkg::in_req_t  in_req,
  output logic               out_valid,
  output iort_pkg::out_rsp_t out_rsp
);
  import iort_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  state_t state_r;

  logic signed [TIME_BITS-1:0] req_s_r;
  logic signed [TIME_BITS-1:0] req_e_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            idx_r;
  logic                        rd_vld_r;
  logic                        hit_r;
  logic                        out_valid_r;
  out_rsp_t                    out_rsp_r;

  logic [2*TIME_BITS-1:0] mem [ENTRIES];
  logic [2*TIME_BITS-1:0] mem_q_r;

  logic signed [TIME_BITS-1:0] q_s;
  logic signed [TIME_BITS-1:0] q_e;
  logic                        overlap;
  logic                        full;
  logic                        mem_we;
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            wr_addr;
  logic signed [TIME_BITS-1:0] in_s;
  logic signed [TIME_BITS-1:0] in_e;

  // Sign-extend or wrap the 32-bit request times to the stored width.
  assign in_s = TIME_BITS'(in_req.req_start);
  assign in_e = TIME_BITS'(in_req.req_end);

  assign q_s     = mem_q_r[2*TIME_BITS-1:TIME_BITS];
  assign q_e     = mem_q_r[TIME_BITS-1:0];
  assign overlap = (q_s < req_e_r) && (req_s_r < q_e);
  assign full    = (count_r == CNT_FULL);
  assign rd_addr = idx_r[IDX_W-1:0];
  assign wr_addr = count_r[IDX_W-1:0];
  // The write lands in ST_DECIDE, after the last scan read is compared, so no compared entry is disturbed.
  assign mem_we  = (state_r == ST_DECIDE) && !hit_r && !full;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {req_s_r, req_e_r};
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= (state_r == ST_SCAN);
      if (rd_vld_r && overlap) begin
        hit_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_s_r <= in_s;
            req_e_r <= in_e;
            idx_r   <= '0;
            hit_r   <= 1'b0;
            state_r <= (count_r == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx_r <= idx_r + 1'b1;
          if (CNT_W'(idx_r + 1'b1) == count_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          out_valid_r <= 1'b1;
          if (hit_r) begin
            out_rsp_r.status       <= STAT_CONFLICT;
            out_rsp_r.stored_count <= COUNT_W'(count_r);
          end else if (full) begin
            out_rsp_r.status       <= STAT_FULL;
            out_rsp_r.stored_count <= COUNT_W'(count_r);
          end else begin
            count_r                <= count_r + 1'b1;
            out_rsp_r.status       <= STAT_ACCEPTED;
            out_rsp_r.stored_count <= COUNT_W'(count_r + 1'b1);
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("booking count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == STAT_FULL) |-> full)
    else $error("full reported while table has room");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(state_r == ST_DECIDE))
    else $error("result strobe outside decide follow-up");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r < count_r))
    else $error("scan read beyond held bookings");

endmodule
